>>> src/smm_pkg.sv
// Shared types and constants of the square matrix multiply unit.
// No dependencies; used by smm_mac, the top level and the testbench.
package smm_pkg;

	localparam int MAX_DIM   = 8;
	localparam int DATA_W    = 32;
	localparam int SIZE_W    = 4;
	localparam int IDX_W     = 3;
	localparam int DEPTH     = MAX_DIM * MAX_DIM;
	localparam int ADDR_W    = 6;
	localparam int COUNT_W   = 7;
	localparam int PADDR_W   = 2;

	// Register map (byte addresses) and reset values
	localparam logic [PADDR_W-1:0] REG_MATRIX_SIZE = 2'd0;
	localparam logic [SIZE_W-1:0]  SIZE_RESET      = 4'd8;

	// One input transaction: an element of A and the matching element of B
	typedef struct packed {
		logic signed [DATA_W-1:0] a_element;
		logic signed [DATA_W-1:0] b_element;
	} in_t;

	// One result transaction: an element of C and the end-of-matrix mark
	typedef struct packed {
		logic signed [DATA_W-1:0] product_element;
		logic                     last_element;
	} out_t;

	// Control flags traveling with one operand pair down the MAC pipeline
	typedef struct packed {
		logic valid;
		logic first;
		logic k_last;
		logic last;
	} mac_ctl_t;

endpackage

>>> src/smm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module smm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/smm_mac.sv
// Multiply-accumulate datapath: multiply stage, accumulator and result register.
// Depends on smm_pkg.
module smm_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [smm_pkg::DATA_W-1:0]    a_s1,
	input  logic [smm_pkg::DATA_W-1:0]    b_s1,
	input  smm_pkg::mac_ctl_t             ctl_s1,
	output logic                          active,
	output smm_pkg::out_t                 result,
	output logic                          strobe
);

	smm_pkg::mac_ctl_t             ctl_s2;
	logic [smm_pkg::DATA_W-1:0]    prod_s2;
	logic [smm_pkg::DATA_W-1:0]    acc_q;
	logic [smm_pkg::DATA_W-1:0]    acc_sum;

	// Restart the sum on the first term of each element
	assign acc_sum = (ctl_s2.first ? '0 : acc_q) + prod_s2;
	assign active  = ctl_s1.valid | ctl_s2.valid;

	// Multiply stage, low word only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= smm_pkg::DATA_W'(a_s1 * b_s1);
	end

	// Accumulate and present a finished element for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= ctl_s2.valid & ctl_s2.k_last;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_q <= acc_sum;
			if (ctl_s2.k_last) begin
				result.product_element <= acc_sum;
				result.last_element    <= ctl_s2.last;
			end
		end
	end

endmodule

>>> src/square_matrix_multiply_unit.sv
// Top level of the square matrix multiply unit: load control, operand RAMs,
// sequencing of the dot products and the APB register. Depends on smm_pkg,
// smm_ram and smm_mac.
//
// Usage:
//   Set matrix_size (1..8; 0 acts as 1, larger values as 8) over APB while idle.
//   Pulse start with one element of A and the element of B at the same
//   row-major position in operand; a transaction is taken when start is high
//   and busy is low. Back-to-back transactions are taken while busy is low.
//   The transaction that completes size*size elements starts the product: busy
//   rises, and a single MAC unit walks C in row-major order, one multiply a
//   cycle, each term passing the read, multiply and accumulate stages of the
//   pipeline. Each element of C appears on result for one cycle with strobe
//   high; last_element marks the final one. Each element follows once its
//   last term is accumulated; busy falls as the final element is registered.
//   The receiver cannot stall; results are never held.
//   Reset clears the load count, the pipeline and sets matrix_size to 8;
//   the operand RAMs are not cleared and need no clearing pass.
module square_matrix_multiply_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  smm_pkg::in_t                  operand,
	output smm_pkg::out_t                 result,
	output logic                          strobe,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smm_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [smm_pkg::SIZE_W-1:0]   size_q;
	logic [smm_pkg::SIZE_W-1:0]   eff_size;
	logic [smm_pkg::COUNT_W-1:0]  total;
	logic [smm_pkg::COUNT_W-1:0]  load_q;
	logic [smm_pkg::COUNT_W-1:0]  load_next;
	logic                         accept;
	logic                         trigger;

	logic                         run_q;
	logic [smm_pkg::SIZE_W-1:0]   dim_q;
	logic [smm_pkg::IDX_W-1:0]    dim_m1;
	logic [smm_pkg::IDX_W-1:0]    i_q;
	logic [smm_pkg::IDX_W-1:0]    j_q;
	logic [smm_pkg::IDX_W-1:0]    k_q;
	logic [smm_pkg::COUNT_W-1:0]  a_pos;
	logic [smm_pkg::COUNT_W-1:0]  b_pos;
	logic [smm_pkg::ADDR_W-1:0]   a_raddr;
	logic [smm_pkg::ADDR_W-1:0]   b_raddr;
	logic [smm_pkg::DATA_W-1:0]   a_s1;
	logic [smm_pkg::DATA_W-1:0]   b_s1;
	smm_pkg::mac_ctl_t            ctl_s1;
	logic                         mac_active;

	// Clamp the configured size to 1..MAX_DIM
	always_comb begin
		if (size_q == '0) begin
			eff_size = smm_pkg::SIZE_W'(1);
		end else if (size_q > smm_pkg::SIZE_W'(smm_pkg::MAX_DIM)) begin
			eff_size = smm_pkg::SIZE_W'(smm_pkg::MAX_DIM);
		end else begin
			eff_size = size_q;
		end
	end

	assign total     = smm_pkg::COUNT_W'(eff_size) * smm_pkg::COUNT_W'(eff_size);
	assign busy      = run_q | mac_active;
	assign accept    = start & ~busy;
	assign load_next = load_q + smm_pkg::COUNT_W'(1);
	assign trigger   = accept & (load_next >= total);

	// Operand addresses: A row-major by (i,k), B by (k,j)
	assign dim_m1  = smm_pkg::IDX_W'(dim_q - smm_pkg::SIZE_W'(1));
	assign a_pos   = smm_pkg::COUNT_W'(i_q) * smm_pkg::COUNT_W'(dim_q)
		+ smm_pkg::COUNT_W'(k_q);
	assign b_pos   = smm_pkg::COUNT_W'(k_q) * smm_pkg::COUNT_W'(dim_q)
		+ smm_pkg::COUNT_W'(j_q);
	assign a_raddr = a_pos[smm_pkg::ADDR_W-1:0];
	assign b_raddr = b_pos[smm_pkg::ADDR_W-1:0];

	smm_ram #(
		.WIDTH(smm_pkg::DATA_W),
		.DEPTH(smm_pkg::DEPTH)
	) u_left_ram (
		.clk  (clk),
		.we   (accept),
		.waddr(load_q[smm_pkg::ADDR_W-1:0]),
		.wdata(operand.a_element),
		.raddr(a_raddr),
		.rdata(a_s1)
	);

	smm_ram #(
		.WIDTH(smm_pkg::DATA_W),
		.DEPTH(smm_pkg::DEPTH)
	) u_right_ram (
		.clk  (clk),
		.we   (accept),
		.waddr(load_q[smm_pkg::ADDR_W-1:0]),
		.wdata(operand.b_element),
		.raddr(b_raddr),
		.rdata(b_s1)
	);

	// Load counting and the i/j/k sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
			run_q  <= 1'b0;
			dim_q  <= smm_pkg::SIZE_RESET;
			i_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= run_q;
			ctl_s1.first  <= (k_q == '0);
			ctl_s1.k_last <= (k_q == dim_m1);
			ctl_s1.last   <= (i_q == dim_m1) & (j_q == dim_m1) & (k_q == dim_m1);
			if (trigger) begin
				load_q <= '0;
				run_q  <= 1'b1;
				dim_q  <= eff_size;
				i_q    <= '0;
				j_q    <= '0;
				k_q    <= '0;
			end else if (accept) begin
				load_q <= load_next;
			end else if (run_q) begin
				// Advance k, then j, then i; drop run after the final term
				if (k_q != dim_m1) begin
					k_q <= k_q + smm_pkg::IDX_W'(1);
				end else begin
					k_q <= '0;
					if (j_q != dim_m1) begin
						j_q <= j_q + smm_pkg::IDX_W'(1);
					end else begin
						j_q <= '0;
						if (i_q != dim_m1) begin
							i_q <= i_q + smm_pkg::IDX_W'(1);
						end else begin
							i_q   <= '0;
							run_q <= 1'b0;
						end
					end
				end
			end
		end
	end

	smm_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.a_s1  (a_s1),
		.b_s1  (b_s1),
		.ctl_s1(ctl_s1),
		.active(mac_active),
		.result(result),
		.strobe(strobe)
	);

	// APB register: matrix_size
	assign pready = 1'b1;
	assign prdata = (paddr == smm_pkg::REG_MATRIX_SIZE) ? {28'd0, size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= smm_pkg::SIZE_RESET;
		end else if (psel & penable & pwrite & pready) begin
			if (paddr == smm_pkg::REG_MATRIX_SIZE) begin
				size_q <= pwdata[smm_pkg::SIZE_W-1:0];
			end
		end
	end

endmodule

>>> tb/square_matrix_multiply_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for square_matrix_multiply_unit: loads operand pairs, predicts C.
// Depends on smm_pkg and the RTL under src; holds its own product tracker class.
module square_matrix_multiply_unit_tb;
	import smm_pkg::*;

	localparam int ITEM_GOAL   = 320;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOW_LIMIT  = 10;

	localparam logic [31:0] WORD_MIN = 32'h8000_0000;
	localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] WORD_NEG = 32'hFFFF_FFFF;

	// Track loaded operands and queue the elements of C they should produce
	class product_tracker;
		logic [DATA_W-1:0]  left_words[DEPTH];
		logic [DATA_W-1:0]  right_words[DEPTH];
		logic [COUNT_W-1:0] loaded;
		logic [SIZE_W-1:0]  size_reg;
		out_t               expected_elements[$];
		int                 errors;

		function new();
			loaded   = '0;
			size_reg = SIZE_RESET;
			errors   = 0;
		endfunction

		function int dim();
			int n;
			n = int'(size_reg);
			if (n == 0)
				n = 1;
			if (n > MAX_DIM)
				n = MAX_DIM;
			return n;
		endfunction

		function int pending();
			return expected_elements.size();
		endfunction

		function void flag(string what, logic [31:0] exp_v, logic [31:0] got_v);
			errors++;
			if (errors <= SHOW_LIMIT)
				$display("ERROR %s: expected %h, got %h at %0t", what, exp_v, got_v, $realtime);
		endfunction

		// Store one operand pair; run the product once the matrix is complete
		function void note_operands(in_t x);
			logic [DATA_W-1:0] acc;
			logic [DATA_W-1:0] prod;
			logic [ADDR_W-1:0] pos;
			out_t              elem;
			int                n;
			n   = dim();
			pos = loaded[ADDR_W-1:0];
			left_words[pos]  = x.a_element;
			right_words[pos] = x.b_element;
			loaded = loaded + COUNT_W'(1);
			if (loaded < n * n)
				return;
			for (int i = 0; i < n; i++) begin
				for (int j = 0; j < n; j++) begin
					acc = '0;
					for (int k = 0; k < n; k++) begin
						prod = left_words[ADDR_W'(i * n + k)] * right_words[ADDR_W'(k * n + j)];
						acc  = acc + prod;
					end
					elem.product_element = acc;
					elem.last_element    = (i == n - 1) && (j == n - 1);
					expected_elements.push_back(elem);
				end
			end
			loaded = '0;
		endfunction

		// Compare one result transaction with the oldest expected element
		function void check_element(out_t got);
			out_t exp_e;
			if (expected_elements.size() == 0) begin
				flag("unexpected element", '0, got.product_element);
				return;
			end
			exp_e = expected_elements.pop_front();
			if (got.product_element !== exp_e.product_element)
				flag("product_element", exp_e.product_element, got.product_element);
			if (got.last_element !== exp_e.last_element)
				flag("last_element", {31'd0, exp_e.last_element}, {31'd0, got.last_element});
		endfunction

		function void check_size_read(logic [31:0] got);
			if (got !== {{(32-SIZE_W){1'b0}}, size_reg})
				flag("matrix_size read", {{(32-SIZE_W){1'b0}}, size_reg}, got);
		endfunction
	endclass

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                start    = 1'b0;
	logic                busy;
	in_t                 operand  = '0;
	out_t                result;
	logic                strobe;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [PADDR_W-1:0]  paddr    = '0;
	logic [31:0]         pwdata   = '0;
	logic [31:0]         prdata;
	logic                pready;

	product_tracker sb = new();
	int             cycles     = 0;
	int             items_sent = 0;
	int             idle_pct   = 7;

	square_matrix_multiply_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.operand (operand),
		.result  (result),
		.strobe  (strobe),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch both handshakes at every edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_operands(operand);
			if (strobe)
				sb.check_element(result);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("square_matrix_multiply_unit: mismatch");
			$finish;
		end
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return WORD_NEG;
			3: return '0;
			4, 5: return $urandom_range(0, 31) - 16;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_t pair(logic [31:0] a, logic [31:0] b);
		in_t p;
		p.a_element = a;
		p.b_element = b;
		return p;
	endfunction

	// Offer one transaction, with random idle cycles ahead of it
	task automatic send_pair(in_t x);
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		operand <= x;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
	endtask

	task automatic send_random(int count);
		for (int i = 0; i < count; i++)
			send_pair(pair(pick_word(), pick_word()));
	endtask

	// Hold off until every expected element has come and the block is idle
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0 || busy);
		repeat (MAX_DIM + 4) @(posedge clk);
	endtask

	task automatic write_size(logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_MATRIX_SIZE;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.size_reg = value[SIZE_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic read_size();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= REG_MATRIX_SIZE;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.check_size_read(prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_size(logic [31:0] value);
		write_size(value);
		read_size();
	endtask

	initial begin
		int code;
		int n;
		int mats;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset value, 1x1 extremes
		read_size();
		set_size(1);
		send_pair(pair(WORD_MIN, WORD_MIN));
		send_pair(pair(WORD_MIN, WORD_MAX));
		send_pair(pair(WORD_MAX, WORD_MAX));
		send_pair(pair(WORD_NEG, WORD_NEG));
		send_pair(pair(32'd0, WORD_MAX));

		// Size zero acts as one
		wait_drained();
		set_size(0);
		send_pair(pair(32'd7, WORD_NEG));
		send_pair(pair(WORD_MAX, 32'd2));

		// Upper write bits ignored; 2x2 of extremes
		wait_drained();
		set_size(32'hABCD_0012);
		send_pair(pair(WORD_MAX, WORD_MIN));
		send_pair(pair(WORD_MIN, WORD_NEG));
		send_pair(pair(WORD_NEG, WORD_MAX));
		send_pair(pair(32'd1, WORD_MIN));

		// Shrink the size after a partial load: next item completes the product
		wait_drained();
		set_size(3);
		send_random(5);
		wait_drained();
		set_size(2);
		send_random(1);

		// Grow the size after a partial load
		wait_drained();
		set_size(2);
		send_random(3);
		wait_drained();
		set_size(3);
		send_random(6);

		// Random phases: mostly small matrices, some partial loads
		for (int phase = 0; items_sent < ITEM_GOAL; phase++) begin
			wait_drained();
			idle_pct = (phase >= 3 && phase <= 5) ? 0 : 7;
			case (phase)
				0: code = 15;
				1: code = 8;
				default: begin
					case ($urandom_range(0, 19))
						0, 1: code = 0;
						2: code = $urandom_range(9, 15);
						3: code = 8;
						default: code = $urandom_range(1, 5);
					endcase
				end
			endcase
			set_size(code);
			n    = sb.dim();
			mats = $urandom_range(1, (48 / (n * n) > 1) ? 48 / (n * n) : 1);
			for (int m = 0; m < mats; m++) begin
				send_random(n * n);
				if (phase == 2 && m == 0)
					wait_drained();
			end
			if ($urandom_range(0, 99) < 20 && n > 1)
				send_random($urandom_range(1, n * n - 1));
		end

		// Drain and decide
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (3 * MAX_DIM) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("square_matrix_multiply_unit: match");
		else
			$display("square_matrix_multiply_unit: mismatch");
		$finish;
	end

endmodule

>>> files.f
src/smm_pkg.sv
src/smm_ram.sv
src/smm_mac.sv
src/square_matrix_multiply_unit.sv
tb/square_matrix_multiply_unit_tb.sv
